// ===== src/assert_macros.svh =====
// Assertion macros used by the timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== src/crt_pkg.sv =====
// Shared types, constants and helpers of the three-channel reload timer.
`default_nettype none
package crt_pkg;

	localparam int PRESCALER_BITS = 12;
	localparam int WORD_W = 32;
	localparam int CTRL_W = 10;
	localparam int NUM_CH = 3;
	localparam int OP_W = 2;
	localparam int OFF_W = 4;

	// Transaction kinds
	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

	// Register word offsets
	localparam logic [OFF_W-1:0] OFF_TOCR  = 4'd0;
	localparam logic [OFF_W-1:0] OFF_TSTR  = 4'd1;
	localparam logic [OFF_W-1:0] OFF_TCOR0 = 4'd2;
	localparam logic [OFF_W-1:0] OFF_TCNT0 = 4'd3;
	localparam logic [OFF_W-1:0] OFF_TCR0  = 4'd4;
	localparam logic [OFF_W-1:0] OFF_TCOR1 = 4'd5;
	localparam logic [OFF_W-1:0] OFF_TCNT1 = 4'd6;
	localparam logic [OFF_W-1:0] OFF_TCR1  = 4'd7;
	localparam logic [OFF_W-1:0] OFF_TCOR2 = 4'd8;
	localparam logic [OFF_W-1:0] OFF_TCNT2 = 4'd9;
	localparam logic [OFF_W-1:0] OFF_TCR2  = 4'd10;

	// Control register fields and masks
	localparam int UNF_BIT = 8;
	localparam int UNIE_BIT = 5;
	localparam logic [CTRL_W-1:0] CTRL_MASK_LOW = 10'h0FF;
	localparam logic [CTRL_W-1:0] CTRL_MASK_CH2 = 10'h2FF;
	localparam logic [WORD_W-1:0] COUNT_RESET = 32'hFFFF_FFFF;

	// Per-channel commands for one executed transaction
	typedef struct packed {
		logic tick;
		logic wr_const;
		logic wr_count;
		logic wr_ctrl;
	} chan_cmd_t;

	// Prescaler edge: low 4+2*TPSC phase bits all zero; TPSC 5 to 7 acts as 0
	function automatic logic tick_due(input logic [PRESCALER_BITS-1:0] phase,
			input logic [2:0] tpsc);
		unique case (tpsc)
			3'd1:    return (phase[5:0] == '0);
			3'd2:    return (phase[7:0] == '0);
			3'd3:    return (phase[9:0] == '0);
			3'd4:    return (phase[11:0] == '0);
			default: return (phase[3:0] == '0);
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== src/crt_channel.sv =====
// One timer channel: constant, count and control registers with reload on underflow.
`default_nettype none
module crt_channel (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire crt_pkg::chan_cmd_t                  cmd,
	input  wire logic [crt_pkg::WORD_W-1:0]          wdata,
	input  wire logic [crt_pkg::CTRL_W-1:0]          ctrl_mask,
	input  wire logic [crt_pkg::PRESCALER_BITS-1:0]  phase_next,
	output logic [crt_pkg::WORD_W-1:0]               const_q,
	output logic [crt_pkg::WORD_W-1:0]               count_q,
	output logic [crt_pkg::CTRL_W-1:0]               ctrl_q,
	output logic                                     irq_next
);
	import crt_pkg::*;

	logic                due;
	logic [WORD_W-1:0]   const_d;
	logic [WORD_W-1:0]   count_d;
	logic [CTRL_W-1:0]   ctrl_d;
	logic [CTRL_W-1:0]   keep;

	assign due = cmd.tick && tick_due(phase_next, ctrl_q[2:0]);

	// Next state: count down or reload, then apply any register write
	always_comb begin
		const_d = const_q;
		count_d = count_q;
		ctrl_d = ctrl_q;
		keep = '0;
		if (due) begin
			if (count_q == '0) begin
				count_d = const_q;
				ctrl_d[UNF_BIT] = 1'b1;
			end else begin
				count_d = count_q - WORD_W'(1);
			end
		end
		if (cmd.wr_const) begin
			const_d = wdata;
		end
		if (cmd.wr_count) begin
			count_d = wdata;
		end
		if (cmd.wr_ctrl) begin
			// Underflow flag may only be cleared by a write
			keep[UNF_BIT] = ctrl_q[UNF_BIT] & wdata[UNF_BIT];
			ctrl_d = (wdata[CTRL_W-1:0] & ctrl_mask) | keep;
		end
	end

	assign irq_next = ctrl_d[UNF_BIT] & ctrl_d[UNIE_BIT];

	// Hold channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			const_q <= COUNT_RESET;
			count_q <= COUNT_RESET;
			ctrl_q <= '0;
		end else begin
			const_q <= const_d;
			count_q <= count_d;
			ctrl_q <= ctrl_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/three_channel_reload_timer_unit.sv =====
// Top level of the three-channel prescaled reload timer.
//
// Usage: every transaction on the slave channel (s_tvalid/s_tready/s_tdata)
// is a clock tick, a register read or a register write. Each one yields
// exactly one transaction on the master channel (m_tvalid/m_tready/m_tdata)
// carrying the read data (zero unless a read) and the per-channel interrupt
// lines taken after the transaction has been applied.
// Pipeline: an accepted transaction passes through the input register and
// then the result register before it is presented on the master channel.
// Throughput is one transaction per cycle while the receiver does not stall;
// the only loop is the register update of a single executed transaction.
// Reset (arst_n low): prescaler phase and start bits clear, counts and
// constants go to all ones, control registers clear, both stages empty.
// A stalled receiver holds the result register; the input register still
// takes one more transaction, after which s_tready drops until m_tready.
`default_nettype none
`include "assert_macros.svh"
module three_channel_reload_timer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [1:0] operation, [5:2] reg_offset, [37:6] write_data, [39:38] zero
	input  wire logic [39:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [31:0] read_data, [34:32] irq_pending, [39:35] zero
	output logic [39:0]      m_tdata
);
	import crt_pkg::*;

	logic                       valid_s1;
	logic [OP_W-1:0]            op_s1;
	logic [OFF_W-1:0]           off_s1;
	logic [WORD_W-1:0]          wdata_s1;
	logic                       out_valid_q;
	logic [WORD_W-1:0]          rdata_q;
	logic [NUM_CH-1:0]          irq_q;
	logic                       advance;
	logic                       exec;
	logic                       is_write;
	logic [PRESCALER_BITS-1:0]  phase_q;
	logic [PRESCALER_BITS-1:0]  phase_next;
	logic [NUM_CH-1:0]          start_q;
	logic                       tocr_q;
	logic [WORD_W-1:0]          rd_mux;
	logic [WORD_W-1:0]          rd_value;
	chan_cmd_t                  cmd [NUM_CH];
	logic [WORD_W-1:0]          const_q [NUM_CH];
	logic [WORD_W-1:0]          count_q [NUM_CH];
	logic [CTRL_W-1:0]          ctrl_q [NUM_CH];
	logic [NUM_CH-1:0]          irq_next;

	localparam logic [OFF_W-1:0] OFF_TCOR [NUM_CH] = '{OFF_TCOR0, OFF_TCOR1, OFF_TCOR2};
	localparam logic [OFF_W-1:0] OFF_TCNT [NUM_CH] = '{OFF_TCNT0, OFF_TCNT1, OFF_TCNT2};
	localparam logic [OFF_W-1:0] OFF_TCR [NUM_CH] = '{OFF_TCR0, OFF_TCR1, OFF_TCR2};

	// Handshake: the stage moves when the result register is free or drained
	assign advance = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign exec = valid_s1 && advance;
	assign is_write = exec && (op_s1 == OP_WRITE);
	assign phase_next = phase_q + PRESCALER_BITS'(1);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= s_tdata[1:0];
			off_s1 <= s_tdata[5:2];
			wdata_s1 <= s_tdata[37:6];
		end
	end

	// Shared prescaler phase, start bits and output control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			start_q <= '0;
			tocr_q <= 1'b0;
		end else begin
			if (exec && (op_s1 == OP_TICK)) begin
				phase_q <= phase_next;
			end
			if (is_write && (off_s1 == OFF_TSTR)) begin
				start_q <= wdata_s1[NUM_CH-1:0];
			end
			if (is_write && (off_s1 == OFF_TOCR)) begin
				tocr_q <= wdata_s1[0];
			end
		end
	end

	// Channels
	for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
		assign cmd[c].tick = exec && (op_s1 == OP_TICK) && start_q[c];
		assign cmd[c].wr_const = is_write && (off_s1 == OFF_TCOR[c]);
		assign cmd[c].wr_count = is_write && (off_s1 == OFF_TCNT[c]);
		assign cmd[c].wr_ctrl = is_write && (off_s1 == OFF_TCR[c]);

		crt_channel u_channel (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd[c]),
			.wdata      (wdata_s1),
			.ctrl_mask  ((c == NUM_CH - 1) ? CTRL_MASK_CH2 : CTRL_MASK_LOW),
			.phase_next (phase_next),
			.const_q    (const_q[c]),
			.count_q    (count_q[c]),
			.ctrl_q     (ctrl_q[c]),
			.irq_next   (irq_next[c])
		);
	end

	// Register read mux; unmapped offsets read as zero
	always_comb begin
		unique case (off_s1)
			OFF_TOCR:  rd_mux = {{(WORD_W-1){1'b0}}, tocr_q};
			OFF_TSTR:  rd_mux = {{(WORD_W-NUM_CH){1'b0}}, start_q};
			OFF_TCOR0: rd_mux = const_q[0];
			OFF_TCNT0: rd_mux = count_q[0];
			OFF_TCR0:  rd_mux = {{(WORD_W-CTRL_W){1'b0}}, ctrl_q[0]};
			OFF_TCOR1: rd_mux = const_q[1];
			OFF_TCNT1: rd_mux = count_q[1];
			OFF_TCR1:  rd_mux = {{(WORD_W-CTRL_W){1'b0}}, ctrl_q[1]};
			OFF_TCOR2: rd_mux = const_q[2];
			OFF_TCNT2: rd_mux = count_q[2];
			OFF_TCR2:  rd_mux = {{(WORD_W-CTRL_W){1'b0}}, ctrl_q[2]};
			default:   rd_mux = '0;
		endcase
	end

	assign rd_value = (op_s1 == OP_READ) ? rd_mux : '0;

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			rdata_q <= rd_value;
			irq_q <= irq_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {5'b0, irq_q, rdata_q};

	// Checks
	`ASSERT_IMPL(a_full_stall, clk, arst_n, valid_s1 && out_valid_q && !m_tready, !s_tready)
	`ASSERT_NEXT(a_rd_zero, clk, arst_n, exec && (op_s1 != OP_READ), rdata_q == '0)
	`ASSERT_NEXT(a_phase_step, clk, arst_n, exec && (op_s1 == OP_TICK), phase_q == $past(phase_next))
	`ASSERT_NEXT(a_phase_hold, clk, arst_n, !(exec && (op_s1 == OP_TICK)), $stable(phase_q))

endmodule
`default_nettype wire

// ===== bench/three_channel_reload_timer_unit_tb.sv =====
// Self-checking testbench for the three-channel reload timer: tick, read and write streams.
module three_channel_reload_timer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crt_pkg::*;

	// Transaction kind with no effect on the timer
	localparam logic [OP_W-1:0] OP_NOP = 2'd3;
	// Highest word offset that the 4-bit field can carry
	localparam logic [OFF_W-1:0] OFF_TOP = 4'd15;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 8;
	localparam int ITEMS_PER_PHASE = 225;

	typedef struct packed {
		logic [WORD_W-1:0] rd;
		logic [NUM_CH-1:0] irq;
	} timer_result_t;

	// Timer state mirror, expected results and mismatch bookkeeping
	class timer_scoreboard;
		logic [PRESCALER_BITS-1:0] phase;
		logic [WORD_W-1:0] count [NUM_CH];
		logic [WORD_W-1:0] reload [NUM_CH];
		logic [CTRL_W-1:0] ctrl [NUM_CH];
		logic [NUM_CH-1:0] running;
		logic out_ctrl;
		timer_result_t awaited[$];
		int errors;
		int transactions;
		int reads;
		int underflows;
		int irq_results;

		function new();
			for (int c = 0; c < NUM_CH; c++) begin
				count[c] = COUNT_RESET;
				reload[c] = COUNT_RESET;
				ctrl[c] = '0;
			end
			phase = '0;
			running = '0;
			out_ctrl = 1'b0;
			errors = 0;
			transactions = 0;
			reads = 0;
			underflows = 0;
			irq_results = 0;
		endfunction

		// Advance the prescaler, then step each running channel on its divided edge
		function void advance_tick();
			int unsigned tpsc;
			int unsigned low_mask;
			phase = phase + 1'b1;
			for (int c = 0; c < NUM_CH; c++) begin
				if (running[c]) begin
					tpsc = ctrl[c][2:0];
					if (tpsc > 4)
						tpsc = 0;
					low_mask = (32'd1 << (4 + 2 * tpsc)) - 1;
					if ((int'(phase) & low_mask) == 0) begin
						if (count[c] == '0) begin
							count[c] = reload[c];
							ctrl[c][UNF_BIT] = 1'b1;
							underflows++;
						end else begin
							count[c] = count[c] - 1'b1;
						end
					end
				end
			end
		endfunction

		function logic [WORD_W-1:0] read_reg(logic [OFF_W-1:0] off);
			int chan;
			chan = (int'(off) - int'(OFF_TCOR0)) / 3;
			case (off)
				OFF_TOCR: return WORD_W'(out_ctrl);
				OFF_TSTR: return WORD_W'(running);
				OFF_TCOR0, OFF_TCOR1, OFF_TCOR2: return reload[chan];
				OFF_TCNT0, OFF_TCNT1, OFF_TCNT2: return count[chan];
				OFF_TCR0, OFF_TCR1, OFF_TCR2: return WORD_W'(ctrl[chan]);
				default: return '0;
			endcase
		endfunction

		function void write_reg(logic [OFF_W-1:0] off, logic [WORD_W-1:0] data);
			logic unf_held;
			logic [CTRL_W-1:0] mask;
			int chan;
			chan = (int'(off) - int'(OFF_TCOR0)) / 3;
			case (off)
				OFF_TOCR: out_ctrl = data[0];
				OFF_TSTR: running = data[NUM_CH-1:0];
				OFF_TCOR0, OFF_TCOR1, OFF_TCOR2: reload[chan] = data;
				OFF_TCNT0, OFF_TCNT1, OFF_TCNT2: count[chan] = data;
				OFF_TCR0, OFF_TCR1, OFF_TCR2: begin
					// UNF can only be cleared by a write
					unf_held = ctrl[chan][UNF_BIT] & data[UNF_BIT];
					mask = (chan == NUM_CH - 1) ? CTRL_MASK_CH2 : CTRL_MASK_LOW;
					ctrl[chan] = data[CTRL_W-1:0] & mask;
					ctrl[chan][UNF_BIT] = unf_held;
				end
				default: ;
			endcase
		endfunction

		// Apply one accepted transaction and queue the result it must produce
		function void note_transaction(logic [OP_W-1:0] op, logic [OFF_W-1:0] off,
				logic [WORD_W-1:0] data);
			timer_result_t res;
			res.rd = '0;
			case (op)
				OP_TICK: advance_tick();
				OP_READ: begin
					res.rd = read_reg(off);
					reads++;
				end
				OP_WRITE: write_reg(off, data);
				default: ;
			endcase
			for (int c = 0; c < NUM_CH; c++)
				res.irq[c] = ctrl[c][UNF_BIT] & ctrl[c][UNIE_BIT];
			if (res.irq != '0)
				irq_results++;
			awaited.push_back(res);
			transactions++;
		endfunction

		task report_mismatch(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
			$display("%0t MISMATCH %s: want %h, got %h", $realtime, what, want, got);
			errors++;
		endtask

		// Compare one output transaction with the oldest queued result
		task check_result(logic [39:0] word);
			timer_result_t want;
			if (awaited.size() == 0) begin
				report_mismatch("unexpected result", '0, word[WORD_W-1:0]);
			end else begin
				want = awaited.pop_front();
				if (word[31:0] !== want.rd)
					report_mismatch("read_data", want.rd, word[31:0]);
				if (word[34:32] !== want.irq)
					report_mismatch("irq_pending", WORD_W'(want.irq), WORD_W'(word[34:32]));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// [1:0] operation, [5:2] reg_offset, [37:6] write_data, [39:38] zero
	logic [39:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	// [31:0] read_data, [34:32] irq_pending, [39:35] zero
	logic [39:0] m_tdata;

	timer_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_off_req = 1'b0;
	logic hold_off_done = 1'b0;
	int quiet_cycles = 0;

	three_channel_reload_timer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Offer one transaction, idling first at random, and hold it until taken
	task automatic send_item(input logic [OP_W-1:0] op, input logic [OFF_W-1:0] off,
			input logic [WORD_W-1:0] data);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {2'b00, data, off, op};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_transaction(op, off, data);
		@(negedge clk);
	endtask

	// Mostly mapped offsets, now and then an unmapped one
	function automatic logic [OFF_W-1:0] pick_offset();
		if ($urandom_range(0, 99) < 88)
			return OFF_W'($urandom_range(OFF_TOCR, OFF_TCR2));
		return OFF_W'($urandom_range(OFF_TCR2 + 1, OFF_TOP));
	endfunction

	// Random transaction, biased so that channels reach underflow often
	task automatic random_item();
		int pick;
		logic [OFF_W-1:0] off;
		logic [WORD_W-1:0] data;
		pick = $urandom_range(0, 99);
		off = pick_offset();
		data = $urandom;
		if (pick < 55) begin
			send_item(OP_TICK, off, data);
		end else if (pick < 72) begin
			send_item(OP_READ, off, data);
		end else if (pick < 97) begin
			case (off)
				OFF_TCNT0, OFF_TCNT1, OFF_TCNT2:
					if ($urandom_range(0, 9) < 7)
						data = $urandom_range(0, 3);
				OFF_TCOR0, OFF_TCOR1, OFF_TCOR2:
					if ($urandom_range(0, 1) == 0)
						data = $urandom_range(0, 5);
				OFF_TCR0, OFF_TCR1, OFF_TCR2:
					// keep the fastest prescaler most of the time
					if ($urandom_range(0, 3) != 0)
						data[2:0] = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(5, 7));
				default: ;
			endcase
			send_item(OP_WRITE, off, data);
		end else begin
			send_item(OP_NOP, off, data);
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_off_done) begin
				m_tready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_done = 1'b1;
			end
			m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Check every output transaction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// Watchdog: end the run after too long without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout after %0d quiet cycles", quiet_cycles);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: masks, TPSC aliasing, an early underflow, UNF keep and clear
		send_item(OP_WRITE, OFF_TOCR, 32'hFFFF_FFFF);
		send_item(OP_WRITE, OFF_TCR0, 32'hFFFF_FFFF);
		send_item(OP_WRITE, OFF_TCR2, 32'hFFFF_FFFF);
		send_item(OP_WRITE, OFF_TCNT0, 32'h0000_0000);
		send_item(OP_WRITE, OFF_TSTR, 32'hFFFF_FFFF);
		repeat (16) send_item(OP_TICK, OFF_TOCR, 32'h0000_0000);
		send_item(OP_READ, OFF_TCR0, 32'hFFFF_FFFF);
		send_item(OP_WRITE, OFF_TCR0, 32'h0000_0100);
		send_item(OP_WRITE, OFF_TCR0, 32'h0000_0000);
		send_item(OP_READ, OFF_TOP, 32'h0000_0000);
		send_item(OP_NOP, OFF_TSTR, 32'hFFFF_FFFF);

		// Random phases: no idling with a long hold-off, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					hold_off_req = 1'b1;
				end
				1: begin
					send_idle_pct = 84;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 84;
				end
				default: begin
					send_idle_pct = 21;
					recv_stall_pct = 21;
				end
			endcase
			repeat (ITEMS_PER_PHASE) random_item();
		end
		s_tvalid = 1'b0;

		// Drain outstanding results, then let the pipeline settle
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d transactions (%0d reads) under four idling patterns",
			sb.transactions, sb.reads);
		$display("Saw %0d channel underflows and %0d results with an interrupt raised",
			sb.underflows, sb.irq_results);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
